// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, clocked, disabled while reset is active (low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property check.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hdl/pgc_pkg.sv =====
package pgc_pkg;

  localparam int unsigned IdxW          = 11;
  localparam int unsigned CpbW          = 8;
  localparam int unsigned BcW           = 3;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned NumChan       = 3;
  localparam int unsigned ColourW       = ChanW * NumChan;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned MaxKeyColours = 6;
  // gradient quotient is below 256, one restoring step per quotient bit
  localparam int unsigned LerpSteps     = ChanW;
  localparam int unsigned ProdW         = ChanW + CpbW;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [ColourW-1:0] colour_t;

  // register indexes on the config port
  localparam cfg_idx_t RegCpb      = 3'd0;
  localparam cfg_idx_t RegBc       = 3'd1;
  localparam cfg_idx_t RegPalette0 = 3'd2;

  localparam logic [CpbW-1:0] CpbReset = 8'd255;
  localparam logic [BcW-1:0]  BcReset  = 3'd6;

  // palette contents after reset, until an entry is written
  function automatic colour_t palette_reset(input logic [2:0] k);
    colour_t c;
    unique case (k)
      3'd0:    c = 24'hFF0000;
      3'd1:    c = 24'hFFFF00;
      3'd2:    c = 24'h00FF00;
      3'd3:    c = 24'h00FFFF;
      3'd4:    c = 24'h0000FF;
      3'd5:    c = 24'hFF00FF;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/pgc_ram.sv =====
module pgc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/palette_gradient_colour.sv =====
// Cyclic palette gradient: maps a colour index onto a band of up to MaxKeyColours
// key colours, linearly interpolated between neighbors, one item per clock.
//
// Command channel: colour_index_i is taken at a rising edge with start high and
// busy low. busy never rises, so an item can enter on every clock.
// Result channel: red_o, green_o, blue_o and out_of_range_o are valid for one
// cycle while done_o is high. The receiver cannot stall; results are never
// held back and the pipeline never stops.
// The pipeline depth is set by the two restoring dividers: one step per
// key-index bit, then one step per bit of the 8-bit gradient quotient.
// Throughput: one item per cycle, sustained.
// Config port: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high. Index 0 steps per key colour, 1 key colour count, 2.. palette
// entries (red 23:16, green 15:8, blue 7:0). Write config only while no item
// is in flight.
// Reset: all in-flight items are dropped; config and palette return to their
// defaults at once (palette through per-entry valid bits, no clearing pass).
// An index at or past the band end returns black with out_of_range_o set.
`include "assert_macros.svh"

module palette_gradient_colour #(
  parameter int unsigned MaxKeyColours = pgc_pkg::MaxKeyColours
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [pgc_pkg::IdxW-1:0]       colour_index_i,
  // result channel
  output logic                           done_o,
  output logic [pgc_pkg::ChanW-1:0]      red_o,
  output logic [pgc_pkg::ChanW-1:0]      green_o,
  output logic [pgc_pkg::ChanW-1:0]      blue_o,
  output logic                           out_of_range_o,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pgc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pgc_pkg::ColourW-1:0]    cfg_data_i
);

  localparam int unsigned IdxW    = pgc_pkg::IdxW;
  localparam int unsigned CpbW    = pgc_pkg::CpbW;
  localparam int unsigned BcW     = pgc_pkg::BcW;
  localparam int unsigned ChanW   = pgc_pkg::ChanW;
  localparam int unsigned NumChan = pgc_pkg::NumChan;
  localparam int unsigned ColourW = pgc_pkg::ColourW;
  localparam int unsigned ProdW   = pgc_pkg::ProdW;
  localparam int unsigned Steps   = pgc_pkg::LerpSteps;
  localparam int unsigned KeyW    = $clog2(MaxKeyColours);
  localparam int unsigned CmpW    = IdxW + 1;
  localparam int unsigned CntW    = BcW + 1;
  localparam int unsigned Latency = KeyW + Steps + 5;
  localparam logic [BcW-1:0] MaxBc = BcW'(MaxKeyColours);

  // ---------------------------------------------------------------------------
  // Config registers and palette store
  // ---------------------------------------------------------------------------
  logic [CpbW-1:0]          cpb_q;
  logic [BcW-1:0]           bc_q;
  logic [BcW-1:0]           bc_sat;
  logic [MaxKeyColours-1:0] pal_vld_q;
  logic                     cfg_wr;
  logic [pgc_pkg::CfgIdxW-1:0] pal_entry;
  logic                     pal_we;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign pal_entry   = cfg_index_i - pgc_pkg::RegPalette0;
  // entries at or past MaxKeyColours are never read, so they are dropped
  assign pal_we      = cfg_wr && (cfg_index_i >= pgc_pkg::RegPalette0)
                       && ({1'b0, pal_entry} < CntW'(MaxKeyColours));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_q     <= pgc_pkg::CpbReset;
      bc_q      <= pgc_pkg::BcReset;
      pal_vld_q <= '0;
    end else begin
      if (cfg_wr && cfg_index_i == pgc_pkg::RegCpb) begin
        cpb_q <= cfg_data_i[CpbW-1:0];
      end
      if (cfg_wr && cfg_index_i == pgc_pkg::RegBc) begin
        bc_q <= cfg_data_i[BcW-1:0];
      end
      if (pal_we) begin
        pal_vld_q[pal_entry[KeyW-1:0]] <= 1'b1;
      end
    end
  end

  assign bc_sat = (bc_q > MaxBc) ? MaxBc : bc_q;

  // band length; zero steps or zero key colours give an empty band
  logic [IdxW-1:0] band;
  assign band = IdxW'({{CpbW{1'b0}}, bc_sat} * {{BcW{1'b0}}, cpb_q});

  // ---------------------------------------------------------------------------
  // Key-index divider: idx / cpb, one quotient bit per stage, MSB first.
  // In range the quotient is below 2**KeyW.
  // ---------------------------------------------------------------------------
  logic            k_vld_q [KeyW+1];
  logic            k_oor_q [KeyW+1];
  logic [IdxW-1:0] k_rem_q [KeyW+1];
  logic [KeyW-1:0] k_quo_q [KeyW+1];
  logic            k_oor_d [KeyW+1];
  logic [IdxW-1:0] k_rem_d [KeyW+1];
  logic [KeyW-1:0] k_quo_d [KeyW+1];

  assign k_oor_d[0] = {1'b0, colour_index_i} >= {1'b0, band};
  assign k_rem_d[0] = colour_index_i;
  assign k_quo_d[0] = '0;

  for (genvar s = 1; s <= KeyW; s++) begin : g_key
    logic [CmpW-1:0] dvs;
    logic [CmpW-1:0] rem_ext;
    logic            ge;
    assign dvs        = CmpW'(cpb_q) << (KeyW - s);
    assign rem_ext    = {1'b0, k_rem_q[s-1]};
    assign ge         = rem_ext >= dvs;
    assign k_oor_d[s] = k_oor_q[s-1];
    assign k_rem_d[s] = ge ? IdxW'(rem_ext - dvs) : k_rem_q[s-1];
    assign k_quo_d[s] = k_quo_q[s-1] | (KeyW'(ge) << (KeyW - s));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= KeyW; s++) begin
        k_vld_q[s] <= 1'b0;
      end
    end else begin
      k_vld_q[0] <= start && !busy;
      for (int s = 1; s <= KeyW; s++) begin
        k_vld_q[s] <= k_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= KeyW; s++) begin
      k_oor_q[s] <= k_oor_d[s];
      k_rem_q[s] <= k_rem_d[s];
      k_quo_q[s] <= k_quo_d[s];
    end
  end

  // ---------------------------------------------------------------------------
  // Palette fetch: this key colour and the next one, wrapping at bc_sat
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0] key_a;
  logic [KeyW:0]   key_inc;
  logic [KeyW-1:0] key_b;
  logic [ColourW-1:0] ram_a;
  logic [ColourW-1:0] ram_b;

  assign key_a   = k_quo_q[KeyW];
  assign key_inc = {1'b0, key_a} + (KeyW+1)'(1);
  assign key_b   = (CntW'(key_inc) == {1'b0, bc_sat}) ? '0 : key_inc[KeyW-1:0];

  pgc_ram #(
    .Width (ColourW),
    .Depth (MaxKeyColours)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (pal_we),
    .waddr_i   (pal_entry[KeyW-1:0]),
    .wdata_i   (cfg_data_i),
    .raddr_a_i (key_a),
    .rdata_a_o (ram_a),
    .raddr_b_i (key_b),
    .rdata_b_o (ram_b)
  );

  logic            f_vld_q;
  logic            f_oor_q;
  logic [CpbW-1:0] f_r_q;
  logic [KeyW-1:0] f_ka_q;
  logic [KeyW-1:0] f_kb_q;
  logic            f_a_ok_q;
  logic            f_b_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= k_vld_q[KeyW];
    end
  end

  always_ff @(posedge clk_i) begin
    f_oor_q  <= k_oor_q[KeyW];
    f_r_q    <= k_rem_q[KeyW][CpbW-1:0];
    f_ka_q   <= key_a;
    f_kb_q   <= key_b;
    f_a_ok_q <= pal_vld_q[key_a];
    f_b_ok_q <= pal_vld_q[key_b];
  end

  // ---------------------------------------------------------------------------
  // Channel split: start value, magnitude of the step and its direction
  // ---------------------------------------------------------------------------
  logic [ColourW-1:0] col_a;
  logic [ColourW-1:0] col_b;

  assign col_a = f_a_ok_q ? ram_a : pgc_pkg::palette_reset(3'(f_ka_q));
  assign col_b = f_b_ok_q ? ram_b : pgc_pkg::palette_reset(3'(f_kb_q));

  logic             d_vld_q;
  logic             d_oor_q;
  logic [CpbW-1:0]  d_r_q;
  logic [ChanW-1:0] d_c0_q   [NumChan];
  logic [ChanW-1:0] d_diff_q [NumChan];
  logic             d_fall_q [NumChan];
  logic [ChanW-1:0] d_c0_d   [NumChan];
  logic [ChanW-1:0] d_diff_d [NumChan];
  logic             d_fall_d [NumChan];

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_chan
    logic [ChanW-1:0] c0;
    logic [ChanW-1:0] c1;
    assign c0           = col_a[ChanW*(NumChan-1-ch) +: ChanW];
    assign c1           = col_b[ChanW*(NumChan-1-ch) +: ChanW];
    assign d_c0_d[ch]   = c0;
    assign d_fall_d[ch] = c1 < c0;
    assign d_diff_d[ch] = (c1 < c0) ? (c0 - c1) : (c1 - c0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_oor_q <= f_oor_q;
    d_r_q   <= f_r_q;
    for (int ch = 0; ch < NumChan; ch++) begin
      d_c0_q[ch]   <= d_c0_d[ch];
      d_diff_q[ch] <= d_diff_d[ch];
      d_fall_q[ch] <= d_fall_d[ch];
    end
  end

  // ---------------------------------------------------------------------------
  // Gradient divider: (diff * r) / cpb per channel. Stage 0 holds the product,
  // then one restoring step per quotient bit. The remainder feeds the ceiling.
  // ---------------------------------------------------------------------------
  logic             l_vld_q  [Steps+1];
  logic             l_oor_q  [Steps+1];
  logic [ProdW-1:0] l_rem_q  [Steps+1][NumChan];
  logic [ChanW-1:0] l_quo_q  [Steps+1][NumChan];
  logic [ChanW-1:0] l_c0_q   [Steps+1][NumChan];
  logic             l_fall_q [Steps+1][NumChan];
  logic [ProdW-1:0] l_rem_d  [Steps+1][NumChan];
  logic [ChanW-1:0] l_quo_d  [Steps+1][NumChan];

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_lerp
    assign l_rem_d[0][ch] = ProdW'(d_diff_q[ch]) * ProdW'(d_r_q);
    assign l_quo_d[0][ch] = '0;
    for (genvar s = 1; s <= Steps; s++) begin : g_step
      logic [ProdW-1:0] dvs;
      logic             ge;
      assign dvs            = ProdW'(cpb_q) << (Steps - s);
      assign ge             = l_rem_q[s-1][ch] >= dvs;
      assign l_rem_d[s][ch] = ge ? (l_rem_q[s-1][ch] - dvs) : l_rem_q[s-1][ch];
      assign l_quo_d[s][ch] = l_quo_q[s-1][ch] | (ChanW'(ge) << (Steps - s));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Steps; s++) begin
        l_vld_q[s] <= 1'b0;
      end
    end else begin
      l_vld_q[0] <= d_vld_q;
      for (int s = 1; s <= Steps; s++) begin
        l_vld_q[s] <= l_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    l_oor_q[0] <= d_oor_q;
    for (int ch = 0; ch < NumChan; ch++) begin
      l_c0_q[0][ch]   <= d_c0_q[ch];
      l_fall_q[0][ch] <= d_fall_q[ch];
    end
    for (int s = 1; s <= Steps; s++) begin
      l_oor_q[s] <= l_oor_q[s-1];
      for (int ch = 0; ch < NumChan; ch++) begin
        l_c0_q[s][ch]   <= l_c0_q[s-1][ch];
        l_fall_q[s][ch] <= l_fall_q[s-1][ch];
      end
    end
    for (int s = 0; s <= Steps; s++) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        l_rem_q[s][ch] <= l_rem_d[s][ch];
        l_quo_q[s][ch] <= l_quo_d[s][ch];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: rising adds the floor, falling subtracts the ceiling
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0] res_d [NumChan];
  logic [ChanW-1:0] res_q [NumChan];
  logic             out_vld_q;
  logic             out_oor_q;

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_out
    logic [ChanW-1:0] q;
    logic             rnz;
    assign q   = l_quo_q[Steps][ch];
    assign rnz = |l_rem_q[Steps][ch];
    assign res_d[ch] = l_oor_q[Steps] ? '0 :
                       l_fall_q[Steps][ch] ? (l_c0_q[Steps][ch] - q - ChanW'(rnz)) :
                                             (l_c0_q[Steps][ch] + q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= l_vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    out_oor_q <= l_oor_q[Steps];
    for (int ch = 0; ch < NumChan; ch++) begin
      res_q[ch] <= res_d[ch];
    end
  end

  assign done_o         = out_vld_q;
  assign out_of_range_o = out_oor_q;
  assign red_o          = res_q[0];
  assign green_o        = res_q[1];
  assign blue_o         = res_q[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_PROP(a_fixed_latency, clk_i, rst_ni,
    (start && !busy) |-> ##Latency done_o, "accepted item did not complete on time")
  `ASSERT_IMPLIES(a_oor_black, clk_i, rst_ni, done_o && out_of_range_o,
    (red_o == '0) && (green_o == '0) && (blue_o == '0), "out-of-band item not black")
  `ASSERT_IMPLIES(a_in_band, clk_i, rst_ni, done_o && !out_of_range_o,
    $past(colour_index_i, Latency) < band, "in-band result for index past band end")

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  // Acceptance to done_o, matching the Latency parameter of the block.
  localparam int unsigned ResultLatency = $clog2(pgc_pkg::MaxKeyColours) + 13;
  // Quiet cycles allowed before the run is called hung. The slowest correct
  // stretch is a sender gap plus the pipeline plus the drain pause.
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned IdxMax = (1 << pgc_pkg::IdxW) - 1;

  typedef pgc_pkg::colour_t palette_t [pgc_pkg::MaxKeyColours];

  // One result item as the block presents it.
  typedef struct packed {
    logic [pgc_pkg::ChanW-1:0] red;
    logic [pgc_pkg::ChanW-1:0] green;
    logic [pgc_pkg::ChanW-1:0] blue;
    logic                      out_of_range;
  } colour_result_t;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [pgc_pkg::IdxW-1:0]   colour_index_i = '0;
  logic                       done_o;
  logic [pgc_pkg::ChanW-1:0]  red_o;
  logic [pgc_pkg::ChanW-1:0]  green_o;
  logic [pgc_pkg::ChanW-1:0]  blue_o;
  logic                       out_of_range_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  pgc_pkg::cfg_idx_t          cfg_index_i = '0;
  pgc_pkg::colour_t           cfg_data_i = '0;

  palette_gradient_colour DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .colour_index_i (colour_index_i),
    .done_o         (done_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .out_of_range_o (out_of_range_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the block's configuration, updated on each accepted
  // write. Reset values match the documented register defaults.
  // ---------------------------------------------------------------------
  logic [pgc_pkg::CpbW-1:0] steps_per_key = pgc_pkg::CpbReset;
  logic [pgc_pkg::BcW-1:0]  key_count     = pgc_pkg::BcReset;
  palette_t                 key_colour    = '{24'hFF0000, 24'hFFFF00, 24'h00FF00,
                                              24'h00FFFF, 24'h0000FF, 24'hFF00FF};

  colour_result_t  expected_colours [$];
  int unsigned     fail_count = 0;
  int unsigned     quiet_cycles = 0;

  // Key colours actually in use: a count above the table size saturates.
  function automatic int unsigned keys_in_use();
    return (32'(key_count) > pgc_pkg::MaxKeyColours) ? pgc_pkg::MaxKeyColours :
                                                       32'(key_count);
  endfunction

  // First index past the band; zero steps or zero keys leave it empty.
  function automatic int unsigned band_end();
    return keys_in_use() * 32'(steps_per_key);
  endfunction

  // Linear step from c0 toward c1 by r/cpb of the way: floor going up,
  // ceiling going down, so the result never overshoots c1.
  function automatic logic [pgc_pkg::ChanW-1:0] blend_channel(input int unsigned c0,
                                                              input int unsigned c1,
                                                              input int unsigned r,
                                                              input int unsigned cpb);
    if (c1 > c0)
      return pgc_pkg::ChanW'(c0 + ((c1 - c0) * r) / cpb);
    else if (c1 < c0)
      return pgc_pkg::ChanW'(c0 - ((c0 - c1) * r + cpb - 1) / cpb);
    return pgc_pkg::ChanW'(c0);
  endfunction

  function automatic colour_result_t predict_colour(input logic [pgc_pkg::IdxW-1:0] idx);
    int unsigned      cpb;
    int unsigned      q;
    int unsigned      r;
    int unsigned      nxt;
    pgc_pkg::colour_t c_from;
    pgc_pkg::colour_t c_to;
    colour_result_t   res;
    cpb = 32'(steps_per_key);
    res = '0;
    // Past the band (covers the empty band too): black, flagged.
    if (32'(idx) >= band_end()) begin
      res.out_of_range = 1'b1;
      return res;
    end
    q      = 32'(idx) / cpb;
    r      = 32'(idx) % cpb;
    nxt    = (q + 1) % keys_in_use();
    c_from = key_colour[q];
    c_to   = key_colour[nxt];
    res.red   = blend_channel(32'(c_from[23:16]), 32'(c_to[23:16]), r, cpb);
    res.green = blend_channel(32'(c_from[15:8]),  32'(c_to[15:8]),  r, cpb);
    res.blue  = blend_channel(32'(c_from[7:0]),   32'(c_to[7:0]),   r, cpb);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // start stays high on return so back-to-back items never glitch it.
  task automatic send_item(input logic [pgc_pkg::IdxW-1:0] idx);
    start          <= 1'b1;
    colour_index_i <= idx;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_colours.push_back(predict_colour(idx));
  endtask

  // Sender idle burst; the index bus carries junk meanwhile.
  task automatic idle_for(input int unsigned n);
    start          <= 1'b0;
    colour_index_i <= pgc_pkg::IdxW'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // Let the pipeline empty before touching config.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk_i);
    repeat (ResultLatency) @(posedge clk_i);
  endtask

  // valid stays high across a burst of writes; the caller lowers it.
  task automatic write_reg(input pgc_pkg::cfg_idx_t idx, input pgc_pkg::colour_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == pgc_pkg::RegCpb)
      steps_per_key = data[pgc_pkg::CpbW-1:0];
    else if (idx == pgc_pkg::RegBc)
      key_count = data[pgc_pkg::BcW-1:0];
    else
      key_colour[idx - pgc_pkg::RegPalette0] = data;
  endtask

  // Writes every register. Junk above the field width checks that the
  // narrow registers ignore the upper data bits.
  task automatic program_registers(input logic [pgc_pkg::CpbW-1:0] cpb,
                                   input logic [pgc_pkg::BcW-1:0] keys,
                                   input palette_t pal);
    wait_idle();
    write_reg(pgc_pkg::RegCpb, {(pgc_pkg::ColourW-pgc_pkg::CpbW)'($urandom), cpb});
    write_reg(pgc_pkg::RegBc, {(pgc_pkg::ColourW-pgc_pkg::BcW)'($urandom), keys});
    for (int k = 0; k < pgc_pkg::MaxKeyColours; k++)
      write_reg(pgc_pkg::RegPalette0 + pgc_pkg::cfg_idx_t'(k), pal[k]);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every done_o cycle is
  // one result item, matched against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    colour_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_colours.size() == 0) begin
        $display("%0t: result with nothing pending: rgb %h %h %h oor %b",
                 $time, red_o, green_o, blue_o, out_of_range_o);
        fail_count++;
      end else begin
        want = expected_colours.pop_front();
        if (red_o !== want.red) begin
          $display("%0t: red expected %h got %h", $time, want.red, red_o);
          fail_count++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green expected %h got %h", $time, want.green, green_o);
          fail_count++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue expected %h got %h", $time, want.blue, blue_o);
          fail_count++;
        end
        if (out_of_range_o !== want.out_of_range) begin
          $display("%0t: out_of_range expected %b got %b", $time,
                   want.out_of_range, out_of_range_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted item, result or register write counts as progress.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= '0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: watchdog, no progress for %0d cycles", $time, StallLimit);
        $display("** palette_gradient_colour: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Default palette straight out of reset: band is 6 * 255 = 1530.
  task automatic test_reset_palette();
    send_item(11'd0);
    send_item(11'd254);
    send_item(11'd255);
    send_item(11'd1529);   // last key blending back into key 0
    send_item(11'd1530);   // first index past the band
    send_item(pgc_pkg::IdxW'(IdxMax));
  endtask

  // Key count 7 saturates to 6; black/white neighbors give full-scale
  // rising and falling gradients at the largest remainder.
  task automatic test_band_edges();
    palette_t pal;
    pal = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'h123456, 24'hFFFFFF};
    program_registers(8'd255, 3'd7, pal);
    send_item(11'd1);
    send_item(11'd254);
    send_item(11'd255);
    send_item(11'd509);
    send_item(11'd1275);
    send_item(11'd1529);
    send_item(11'd1530);
    send_item(11'd1024);
  endtask

  // Zero steps per key, then zero keys: every index lies past the band.
  task automatic test_empty_band();
    palette_t pal;
    pal = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    program_registers(8'd0, 3'd6, pal);
    send_item(11'd0);
    send_item(pgc_pkg::IdxW'(IdxMax));
    program_registers(8'd5, 3'd0, pal);
    send_item(11'd0);
    send_item(11'd3);
  endtask

  // One key, one step: index 0 is the key itself, index 1 is out.
  task automatic test_single_key();
    palette_t pal;
    pal = '{24'hA5C3E1, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
    program_registers(8'd1, 3'd1, pal);
    send_item(11'd0);
    send_item(11'd1);
  endtask

  function automatic palette_t random_palette();
    palette_t pal;
    for (int k = 0; k < pgc_pkg::MaxKeyColours; k++) begin
      case ($urandom_range(0, 5))
        0:       pal[k] = '0;
        1:       pal[k] = '1;
        default: pal[k] = pgc_pkg::colour_t'($urandom);
      endcase
    end
    return pal;
  endfunction

  // Steps per key leaning on the extremes; zero now and then.
  function automatic logic [pgc_pkg::CpbW-1:0] random_steps();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3, 4:    return pgc_pkg::CpbW'($urandom_range(2, 8));
      default: return pgc_pkg::CpbW'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly in-band indices, where the gradient logic lives; some beyond.
  task automatic send_random_item();
    if (band_end() != 0 && $urandom_range(0, 9) < 8)
      send_item(pgc_pkg::IdxW'($urandom_range(0, band_end() - 1)));
    else
      send_item(pgc_pkg::IdxW'($urandom_range(0, IdxMax)));
  endtask

  // Random settings per phase, with random sender gaps between items.
  // Some phases gap often, others run mostly back to back.
  task automatic test_random_palettes();
    int unsigned gap_odds;
    for (int phase = 0; phase < 7; phase++) begin
      program_registers(random_steps(),
                        ($urandom_range(0, 9) == 0) ? 3'd0 :
                                                      pgc_pkg::BcW'($urandom_range(1, 7)),
                        random_palette());
      gap_odds = (phase % 2 == 0) ? 3 : 12;
      for (int n = 0; n < 200; n++) begin
        send_random_item();
        if ($urandom_range(1, gap_odds) == 1)
          idle_for($urandom_range(1, 13));
      end
    end
  endtask

  // Closing stretch at full rate, no idling at all.
  task automatic test_streaming();
    program_registers(pgc_pkg::CpbW'($urandom_range(1, 255)),
                      pgc_pkg::BcW'($urandom_range(1, 7)),
                      random_palette());
    for (int n = 0; n < 300; n++)
      send_random_item();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_palette();
    test_band_edges();
    test_empty_band();
    test_single_key();
    test_random_palettes();
    test_streaming();
    wait_idle();
    if (fail_count == 0)
      $display("** palette_gradient_colour: PASSED **");
    else
      $display("** palette_gradient_colour: FAILED **");
    $finish;
  end

endmodule
